// ===== hw/rtl/hls_pkg.sv =====
// shared types and angle constants for the hls to rgb converter
package hls_pkg;

	// angles in sixteenths of a degree
	localparam int DEG60  = 960;
	localparam int DEG120 = 1920;
	localparam int DEG180 = 2880;
	localparam int DEG240 = 3840;
	localparam int DEG360 = 5760;

	// floor(2^16 / 15), used for the divide by 960 as (x >> 6) / 15
	localparam int RECIP15 = 4369;

	typedef struct packed {
		logic [12:0] hue;
		logic [12:0] lightness;
		logic [12:0] saturation;
		logic        hue_undefined;
	} hls_t;

	typedef struct packed {
		logic [12:0] red;
		logic [12:0] green;
		logic [12:0] blue;
	} rgb_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [12:0] hue;
		logic [12:0] l;
		logic [12:0] s;
		logic [12:0] ls;
		logic        low_half;
		logic        grey;
	} work_t;

endpackage

// ===== hw/rtl/hls_front.sv =====
// front end: input register, range saturation, hue wrap and the l*s product
module hls_front #(
	parameter int COLOR_FRAC_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hls_valid,
	output logic          hls_stall,
	input  hls_pkg::hls_t hls_data,
	output logic          push_valid,
	output hls_pkg::work_t push_data,
	input  logic          push_full
);

	localparam int ONE_I = 1 << COLOR_FRAC_BITS;
	localparam logic [17:0] ONE  = 18'(ONE_I);
	localparam logic [17:0] HALF = 18'(ONE_I >> 1);
	localparam logic [12:0] HUE_WRAP = 13'(hls_pkg::DEG360);

	logic        v_s1;
	logic [12:0] hue_s1;
	logic [12:0] l_s1;
	logic [12:0] s_s1;
	logic        undef_s1;

	logic [12:0] hue_c;
	logic [12:0] l_c;
	logic [12:0] s_c;
	logic [25:0] prod;

	assign hls_stall  = v_s1 && push_full;
	assign push_valid = v_s1 && !push_full;

	always_comb begin
		hue_c = (hls_data.hue >= HUE_WRAP) ? hls_data.hue - HUE_WRAP : hls_data.hue;
		l_c = ({5'b0, hls_data.lightness} > ONE) ? ONE[12:0] : hls_data.lightness;
		s_c = ({5'b0, hls_data.saturation} > ONE) ? ONE[12:0] : hls_data.saturation;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!hls_stall) begin
			v_s1 <= hls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hls_valid && !hls_stall) begin
			hue_s1   <= hue_c;
			l_s1     <= l_c;
			s_s1     <= s_c;
			undef_s1 <= hls_data.hue_undefined;
		end
	end

	always_comb begin
		prod = {13'b0, l_s1} * {13'b0, s_s1};
		push_data.hue      = hue_s1;
		push_data.l        = l_s1;
		push_data.s        = s_s1;
		push_data.ls       = 13'(prod >> COLOR_FRAC_BITS);
		push_data.low_half = ({5'b0, l_s1} <= HALF);
		push_data.grey     = (s_s1 == 13'd0) || undef_s1;
	end

endmodule

// ===== hw/rtl/hls_fifo.sv =====
// two-entry queue between the front end and the conversion pipeline
module hls_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  hls_pkg::work_t push_data,
	output logic           full,
	output logic           pop_valid,
	output hls_pkg::work_t pop_data,
	input  logic           pop_take
);

	hls_pkg::work_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_take && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !full) else $error("front pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_take |-> pop_valid) else $error("back took from an empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count did not follow a lone push");

endmodule

// ===== hw/rtl/hls_back.sv =====
// back end: m1/m2, hue ramp segments, ramp multiply, divide by 60 degrees, clamp
module hls_back #(
	parameter int COLOR_FRAC_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  hls_pkg::work_t pop_data,
	output logic           pop_take,
	output logic           rgb_valid,
	input  logic           rgb_stall,
	output hls_pkg::rgb_t  rgb_data
);

	localparam int ONE_I = 1 << COLOR_FRAC_BITS;
	localparam logic signed [18:0] ONE = 19'(ONE_I);

	localparam logic signed [13:0] A60  = 14'(hls_pkg::DEG60);
	localparam logic signed [13:0] A120 = 14'(hls_pkg::DEG120);
	localparam logic signed [13:0] A180 = 14'(hls_pkg::DEG180);
	localparam logic signed [13:0] A240 = 14'(hls_pkg::DEG240);
	localparam logic signed [13:0] A360 = 14'(hls_pkg::DEG360);
	localparam logic [30:0] RECIP = 31'(hls_pkg::RECIP15);

	localparam logic [1:0] SEG_RISE = 2'd0;
	localparam logic [1:0] SEG_HIGH = 2'd1;
	localparam logic [1:0] SEG_FALL = 2'd2;
	localparam logic [1:0] SEG_LOW  = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] a;
	} seg_t;

	// values that ride along the pipeline unchanged
	typedef struct packed {
		logic signed [15:0] m1;
		logic [13:0]        m2;
		logic [2:0][1:0]    mode;
		logic               grey;
		logic [12:0]        l;
	} side_t;

	function automatic seg_t classify(input logic signed [13:0] ang);
		logic signed [13:0] w;
		seg_t               res;
		w = ang;
		if (w > A360) begin
			w = w - A360;
		end else if (w < 14'sd0) begin
			w = w + A360;
		end
		if (w < A60) begin
			res.mode = SEG_RISE;
			res.a    = 10'(w);
		end else if (w < A180) begin
			res.mode = SEG_HIGH;
			res.a    = 10'd0;
		end else if (w < A240) begin
			res.mode = SEG_FALL;
			res.a    = 10'(A240 - w);
		end else begin
			res.mode = SEG_LOW;
			res.a    = 10'd0;
		end
		return res;
	endfunction

	logic v_s2, v_s3, v_s4, v_s5;
	logic en_s2, en_s3, en_s4, en_s5;

	side_t            side_s2, side_s3, side_s4;
	logic [13:0]      diff_s2;
	logic [2:0][9:0]  a_s2;
	logic [2:0][23:0] prod_s3;
	logic [2:0][17:0] y_s4;
	logic [2:0][14:0] q0_s4;
	hls_pkg::rgb_t    out_s5;

	side_t              side_c;
	logic [13:0]        diff_c;
	logic [2:0][9:0]    a_c;
	logic [13:0]        m2_c;
	logic [13:0]        half_diff;
	logic signed [13:0] h_c;
	logic signed [13:0] ang_c [3];
	seg_t               seg_c [3];
	logic [2:0][30:0]   qm_c;
	logic [2:0][12:0]   chan_c;

	// advance when the next stage is empty or moving
	assign en_s5    = !v_s5 || !rgb_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign pop_take = pop_valid && en_s2;

	assign rgb_valid = v_s5;
	assign rgb_data  = out_s5;

	always_comb begin
		if (pop_data.low_half) begin
			m2_c = {1'b0, pop_data.l} + {1'b0, pop_data.ls};
		end else begin
			m2_c = {1'b0, pop_data.l} + {1'b0, pop_data.s} - {1'b0, pop_data.ls};
		end
		// m2 - m1 = 2 * (m2 - l), never negative
		half_diff   = m2_c - {1'b0, pop_data.l};
		diff_c      = {half_diff[12:0], 1'b0};
		side_c.m1   = $signed({2'b0, pop_data.l, 1'b0}) - $signed({2'b0, m2_c});
		side_c.m2   = m2_c;
		side_c.grey = pop_data.grey;
		side_c.l    = pop_data.l;
		h_c      = $signed({1'b0, pop_data.hue});
		ang_c[0] = h_c + A120;
		ang_c[1] = h_c;
		ang_c[2] = h_c - A120;
		for (int c = 0; c < 3; c++) begin
			seg_c[c]       = classify(ang_c[c]);
			side_c.mode[c] = seg_c[c].mode;
			a_c[c]         = seg_c[c].a;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qm_c[c] = 31'(prod_s3[c][23:6]) * RECIP;
		end
	end

	// reciprocal quotient is low by at most one: one compare and step
	always_comb begin
		logic [18:0]        q15;
		logic [18:0]        rem;
		logic [14:0]        q;
		logic signed [18:0] val;
		for (int c = 0; c < 3; c++) begin
			q15 = {q0_s4[c], 4'b0} - {4'b0, q0_s4[c]};
			rem = {1'b0, y_s4[c]} - q15;
			q   = (rem >= 19'd15) ? q0_s4[c] + 15'd1 : q0_s4[c];
			case (side_s4.mode[c])
				SEG_RISE, SEG_FALL: val = {{3{side_s4.m1[15]}}, side_s4.m1} + {4'b0, q};
				SEG_HIGH:           val = {5'b0, side_s4.m2};
				SEG_LOW:            val = {{3{side_s4.m1[15]}}, side_s4.m1};
				default:            val = {{3{side_s4.m1[15]}}, side_s4.m1};
			endcase
			if (side_s4.grey) begin
				val = {6'b0, side_s4.l};
			end
			if (val < 19'sd0) begin
				val = 19'sd0;
			end else if (val > ONE) begin
				val = ONE;
			end
			chan_c[c] = val[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= pop_valid;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && pop_valid) begin
			side_s2 <= side_c;
			diff_s2 <= diff_c;
			a_s2    <= a_c;
		end
		if (en_s3 && v_s2) begin
			side_s3 <= side_s2;
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= {10'b0, diff_s2} * {14'b0, a_s2[c]};
			end
		end
		if (en_s4 && v_s3) begin
			side_s4 <= side_s3;
			for (int c = 0; c < 3; c++) begin
				y_s4[c]  <= prod_s3[c][23:6];
				q0_s4[c] <= qm_c[c][30:16];
			end
		end
		if (en_s5 && v_s4) begin
			out_s5.red   <= chan_c[0];
			out_s5.green <= chan_c[1];
			out_s5.blue  <= chan_c[2];
		end
	end

endmodule

// ===== hw/rtl/hls_to_rgb.sv =====
// top level of the hls to rgb color converter
// Converts one color per clock while the output is not stalled, from hue
// (1/16 degree), lightness and saturation to red, green and blue with
// COLOR_FRAC_BITS fraction bits. A front register saturates the inputs,
// wraps the hue and forms l*s; a two-entry queue then feeds a four-stage
// back pipeline (m1/m2 and hue ramp segments, ramp multiply, reciprocal
// multiply for the divide by 60 degrees, correction and clamp into the
// output register). Sustained rate is one transfer per clock on each side
// while the output is not stalled; each input passes the front register, the
// queue and the four back stages. In steady streaming the queue lets the
// front take one more input after the output stalls.
module hls_to_rgb #(
	parameter int COLOR_FRAC_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hls_valid,
	output logic          hls_stall,
	input  hls_pkg::hls_t hls_data,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output hls_pkg::rgb_t rgb_data
);

	logic           push_valid;
	hls_pkg::work_t push_data;
	logic           push_full;
	logic           pop_valid;
	hls_pkg::work_t pop_data;
	logic           pop_take;

	hls_front #(
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hls_valid (hls_valid),
		.hls_stall (hls_stall),
		.hls_data  (hls_data),
		.push_valid(push_valid),
		.push_data (push_data),
		.push_full (push_full)
	);

	hls_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data (push_data),
		.full      (push_full),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_take  (pop_take)
	);

	hls_back #(
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_data (pop_data),
		.pop_take (pop_take),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.rgb_data (rgb_data)
	);

endmodule
